// ----- rtl/cbts_pkg.sv -----
// cbts_pkg: shared types and constants for the CAN bit timing search block.
// Used by cbts_div and can_bit_timing_search; no dependencies.

package cbts_pkg;

    // search bounds
    localparam int DIV_MAX    = 15;
    localparam int QUANTA_MAX = 32;
    localparam int SEG_MAX    = 17;
    localparam int SEG_BASE   = 3;
    localparam int SJW_CAP    = 3;

    // port widths
    localparam int CLK_W  = 27;
    localparam int BAUD_W = 20;
    localparam int DIV_W  = 4;
    localparam int WORD_W = 15;

    localparam logic [CLK_W-1:0] CLK_RESET = 27'd48000000;

    // loop counter widths, derived from the bounds
    localparam int D_W    = $clog2(DIV_MAX + 1) > 0 ? $clog2(DIV_MAX + 1) : 1;
    localparam int DP1_W  = $clog2(DIV_MAX + 2);
    localparam int Q_W    = $clog2(QUANTA_MAX + 1);
    localparam int S_W    = $clog2(SEG_MAX + 1);
    localparam int BASE_W = $clog2(QUANTA_MAX * (DIV_MAX + 1) + 1);
    localparam int PROD_W = $clog2(SEG_MAX * QUANTA_MAX * (DIV_MAX + 1) + 1);

    // scratch width for the timing word fields
    localparam int FLD_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SEARCH,
        ST_WRITE
    } t_state;

endpackage

// ----- rtl/cbts_div.sv -----
// cbts_div: restoring divider, one quotient bit per cycle.
// Depends on cbts_pkg for the dividend and divisor widths.

module cbts_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cbts_pkg::CLK_W-1:0]  i_dividend,
    input  logic [cbts_pkg::BAUD_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [cbts_pkg::CLK_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(cbts_pkg::CLK_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [cbts_pkg::BAUD_W-1:0] r_rem;
    logic [cbts_pkg::CLK_W-1:0]  r_quo;

    logic [cbts_pkg::BAUD_W:0]   shifted;
    logic [cbts_pkg::BAUD_W:0]   diff;
    logic                        fits;

    assign shifted = {r_rem, r_quo[cbts_pkg::CLK_W-1]};
    assign diff    = shifted - {1'b0, i_divisor};
    assign fits    = shifted >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(cbts_pkg::CLK_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: divisor must hold steady while busy
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[cbts_pkg::BAUD_W-1:0] : shifted[cbts_pkg::BAUD_W-1:0];
            r_quo <= {r_quo[cbts_pkg::CLK_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // remainder always stays below the divisor
    a_rem_lt_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < i_divisor))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("divider restarted while busy");

endmodule

// ----- rtl/can_bit_timing_search.sv -----
// can_bit_timing_search: exact CAN bit-timing search, top level.
// Depends on cbts_pkg and cbts_div.
//
// Usage:
//   Configuration: i_cfg_we writes i_cfg_data into the peripheral clock
//   register (hertz) at that clock edge. Write it only while the block is idle.
//   Input channel: i_valid / o_ready carry one beat holding i_baud, the bit
//   rate wanted. o_ready is high only while the block is idle; it drops for
//   the whole search of one beat.
//   Output channel: o_valid / i_ready carry one result beat per input beat:
//   o_found, o_clock_divider, o_timing_word. Nothing found gives all zeros.
// Sequencing:
//   A zero baud skips the work: the sequencer goes straight to the result write.
//   Otherwise the clocks per bit comes from a restoring divider (one bit
//   per cycle), then one candidate is tested per cycle with a few small
//   adders that step the running product seg * quanta * (div + 1). The
//   search visits up to 16 * 32 * 15 = 7680 candidates. One beat at a time:
//   the next beat is taken from the cycle after the result is registered.
// Reset: the clock register goes to 48 MHz, the sequencer idles, o_valid low.
// Stall: a pending result waits in the output register; the block takes the
//   next beat meanwhile and, if that one finishes first, holds its result
//   until the output register frees up.

module can_bit_timing_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cbts_pkg::CLK_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cbts_pkg::BAUD_W-1:0] i_baud,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_found,
    output logic [cbts_pkg::DIV_W-1:0]  o_clock_divider,
    output logic [cbts_pkg::WORD_W-1:0] o_timing_word
);

    localparam int D_W    = cbts_pkg::D_W;
    localparam int DP1_W  = cbts_pkg::DP1_W;
    localparam int Q_W    = cbts_pkg::Q_W;
    localparam int S_W    = cbts_pkg::S_W;
    localparam int BASE_W = cbts_pkg::BASE_W;
    localparam int PROD_W = cbts_pkg::PROD_W;
    localparam int CLK_W  = cbts_pkg::CLK_W;
    localparam int FLD_W  = cbts_pkg::FLD_W;

    cbts_pkg::t_state r_state, n_state;

    // config
    logic [CLK_W-1:0] r_clk_hz;

    // request and divider
    logic [cbts_pkg::BAUD_W-1:0] r_baud;
    logic [CLK_W-1:0]            div_quo;
    logic                        div_done;
    logic [CLK_W-1:0]            r_cpb;       // clocks per bit

    // search counters; invariant: r_base = q*(d+1), r_prod = s*r_base
    logic [D_W-1:0]    r_d;
    logic [Q_W-1:0]    r_q;
    logic [S_W-1:0]    r_s;
    logic [BASE_W-1:0] r_base;
    logic [PROD_W-1:0] r_prod;

    // pending result
    logic                        r_res_found;
    logic [cbts_pkg::DIV_W-1:0]  r_res_div;
    logic [cbts_pkg::WORD_W-1:0] r_res_word;

    // output register
    logic                        r_o_valid;
    logic                        r_o_found;
    logic [cbts_pkg::DIV_W-1:0]  r_o_div;
    logic [cbts_pkg::WORD_W-1:0] r_o_word;

    // decoded controls
    logic accept;
    logic div_start;
    logic out_free;

    // search step decode
    logic              hit;
    logic              s_last, q_last, d_last;
    logic [DP1_W-1:0]  dp1;
    logic [BASE_W-1:0] base_q_step;
    logic [BASE_W-1:0] base_d_step;
    logic [PROD_W-1:0] prod_q_step;
    logic [PROD_W-1:0] prod_d_step;

    // timing word fields
    logic [FLD_W-1:0] rest, seg1, seg2, sjw, qm1;
    logic [cbts_pkg::WORD_W-1:0] word;

    cbts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_clk_hz),
        .i_divisor  (r_baud),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign out_free = !r_o_valid || i_ready;

    // candidate compare and step values
    assign hit    = {{(CLK_W-PROD_W){1'b0}}, r_prod} == r_cpb;
    assign s_last = r_s == S_W'(cbts_pkg::SEG_MAX);
    assign q_last = r_q == Q_W'(cbts_pkg::QUANTA_MAX);
    assign d_last = r_d == D_W'(cbts_pkg::DIV_MAX);

    assign dp1         = DP1_W'(r_d) + DP1_W'(1);
    assign base_q_step = r_base + BASE_W'(dp1);
    assign base_d_step = BASE_W'(dp1) + BASE_W'(1);
    assign prod_q_step = PROD_W'(base_q_step) + (PROD_W'(base_q_step) << 1);
    assign prod_d_step = PROD_W'(base_d_step) + (PROD_W'(base_d_step) << 1);

    // seg1 = floor(rest/2), seg2 = rest - seg1, jump width capped
    assign rest = FLD_W'(r_s) - FLD_W'(cbts_pkg::SEG_BASE);
    assign seg1 = rest >> 1;
    assign seg2 = rest - seg1;
    assign sjw  = (seg1 > FLD_W'(cbts_pkg::SJW_CAP)) ? FLD_W'(cbts_pkg::SJW_CAP) : seg1;
    assign qm1  = FLD_W'(r_q) - FLD_W'(1);
    assign word = {seg2[2:0], seg1[3:0], sjw[1:0], qm1[5:0]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cbts_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_baud == '0) ? cbts_pkg::ST_WRITE : cbts_pkg::ST_DIVIDE;
                end
            end
            cbts_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    n_state = cbts_pkg::ST_SEARCH;
                end
            end
            cbts_pkg::ST_SEARCH: begin
                if (hit || (s_last && q_last && d_last)) begin
                    n_state = cbts_pkg::ST_WRITE;
                end
            end
            cbts_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = cbts_pkg::ST_IDLE;
                end
            end
            default: n_state = cbts_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready   = 1'b0;
        div_start = 1'b0;
        case (r_state)
            cbts_pkg::ST_IDLE:   o_ready = 1'b1;
            cbts_pkg::ST_DIVIDE: div_start = 1'b0;
            cbts_pkg::ST_SEARCH: o_ready = 1'b0;
            cbts_pkg::ST_WRITE:  o_ready = 1'b0;
            default:             o_ready = 1'b0;
        endcase
        // kick the divider on the accept edge of a nonzero rate; its first
        // shift comes at the next edge, by which time r_baud holds the rate
        if (r_state == cbts_pkg::ST_IDLE && r_state != n_state
            && n_state == cbts_pkg::ST_DIVIDE) begin
            div_start = 1'b1;
        end
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cbts_pkg::ST_IDLE;
            r_clk_hz  <= cbts_pkg::CLK_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_clk_hz <= i_cfg_data;
            end
            if (r_state == cbts_pkg::ST_WRITE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_baud      <= i_baud;
            r_res_found <= 1'b0;
            r_res_div   <= '0;
            r_res_word  <= '0;
        end
        if (div_done) begin
            r_cpb  <= div_quo;
            r_d    <= '0;
            r_q    <= Q_W'(1);
            r_s    <= S_W'(cbts_pkg::SEG_BASE);
            r_base <= BASE_W'(1);
            r_prod <= PROD_W'(cbts_pkg::SEG_BASE);
        end else if (r_state == cbts_pkg::ST_SEARCH) begin
            if (hit) begin
                r_res_found <= 1'b1;
                r_res_div   <= cbts_pkg::DIV_W'(r_d);
                r_res_word  <= word;
            end else if (!s_last) begin
                r_s    <= r_s + S_W'(1);
                r_prod <= r_prod + PROD_W'(r_base);
            end else if (!q_last) begin
                r_q    <= r_q + Q_W'(1);
                r_s    <= S_W'(cbts_pkg::SEG_BASE);
                r_base <= base_q_step;
                r_prod <= prod_q_step;
            end else if (!d_last) begin
                r_d    <= r_d + D_W'(1);
                r_q    <= Q_W'(1);
                r_s    <= S_W'(cbts_pkg::SEG_BASE);
                r_base <= base_d_step;
                r_prod <= prod_d_step;
            end
        end
        if (r_state == cbts_pkg::ST_WRITE && out_free) begin
            r_o_found <= r_res_found;
            r_o_div   <= r_res_div;
            r_o_word  <= r_res_word;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_found         = r_o_found;
    assign o_clock_divider = r_o_div;
    assign o_timing_word   = r_o_word;

    // running product really is seg * quanta * (div + 1)
    a_prod_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cbts_pkg::ST_SEARCH |->
            (r_prod == PROD_W'(PROD_W'(r_s) * PROD_W'(r_base))))
        else $error("running product out of step");

    a_base_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cbts_pkg::ST_SEARCH |->
            (r_base == BASE_W'(BASE_W'(r_q) * BASE_W'(dp1))))
        else $error("quanta base out of step");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cbts_pkg::ST_SEARCH |->
            (r_s >= S_W'(cbts_pkg::SEG_BASE) && r_s <= S_W'(cbts_pkg::SEG_MAX)))
        else $error("segment counter out of range");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == cbts_pkg::ST_DIVIDE)
        else $error("divider finished outside the divide phase");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_found) |-> (r_o_div == '0 && r_o_word == '0))
        else $error("miss result carries nonzero timing");

endmodule
